>>> hw/rtl/xseu_pkg.sv
package xseu_pkg;

    // Default size of the byte-wide data memory.
    localparam int unsigned MEM_BYTES_DEF = 65536;

    // Architectural register file.
    localparam int unsigned NUM_REGS  = 8;
    localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);

    // Instruction queue between front and back.
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // Sign bit of a 16-bit result.
    localparam logic [15:0] SIGN_BIT = 16'h8000;

    // Operation codes as they arrive on the kind field.
    localparam logic [2:0] KIND_MOV = 3'd0;
    localparam logic [2:0] KIND_ADD = 3'd1;
    localparam logic [2:0] KIND_SUB = 3'd2;
    localparam logic [2:0] KIND_CMP = 3'd3;
    localparam logic [2:0] KIND_JNE = 3'd4;

    // Source operand codes; both upper codes select a memory word.
    localparam logic [1:0] SRC_REG = 2'd0;
    localparam logic [1:0] SRC_IMM = 2'd1;

    typedef enum logic [2:0] {
        OP_MOV,
        OP_ADD,
        OP_SUB,
        OP_CMP,
        OP_JNE,
        OP_NOP
    } op_t;

    typedef enum logic {
        BS_CLEAR,
        BS_RUN
    } bstate_t;

    // Classified instruction as it travels through the queue.
    typedef struct packed {
        op_t                  op;
        logic                 dest_mem;
        logic                 src_mem;
        logic                 src_imm;
        logic [3:0]           dest_code;
        logic                 dest_ok;
        logic [REG_IDX_W-1:0] dest_idx;
        logic                 src_ok;
        logic [REG_IDX_W-1:0] src_idx;
        logic                 base_ok;
        logic [REG_IDX_W-1:0] base_idx;
        logic                 index_ok;
        logic [REG_IDX_W-1:0] index_idx;
        logic [15:0]          immediate;
        logic [15:0]          displacement;
        logic [2:0]           length;
    } uop_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // A register code names a real register only in the range one to eight.
    function automatic logic reg_code_ok(input logic [3:0] code);
        return (code >= 4'd1) && (code <= 4'd8);
    endfunction

    function automatic logic [REG_IDX_W-1:0] reg_code_idx(input logic [3:0] code);
        logic [3:0] t;
        t = code - 4'd1;
        return t[REG_IDX_W-1:0];
    endfunction

endpackage

>>> hw/rtl/xseu_front.sv
module xseu_front (
    input  logic [2:0]    kind,
    input  logic          dest_is_memory,
    input  logic [1:0]    source_kind,
    input  logic [3:0]    dest_reg,
    input  logic [3:0]    source_reg,
    input  logic [3:0]    base_reg,
    input  logic [3:0]    index_reg,
    input  logic [15:0]   immediate,
    input  logic [15:0]   displacement,
    input  logic [2:0]    length,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          clearing,
    input  xseu_pkg::qstat_t q_stat,
    output logic          push,
    output xseu_pkg::uop_t push_uop
);
    import xseu_pkg::*;

    // Words are held off while memory is being cleared or the queue is full.
    assign in_stall = clearing || q_stat.full;
    assign push     = in_valid && !in_stall;

    // Classify the incoming word into a queue entry.
    always_comb
    begin
        push_uop = '0;
        case (kind)
            KIND_MOV: push_uop.op = OP_MOV;
            KIND_ADD: push_uop.op = OP_ADD;
            KIND_SUB: push_uop.op = OP_SUB;
            KIND_CMP: push_uop.op = OP_CMP;
            KIND_JNE: push_uop.op = OP_JNE;
            default:  push_uop.op = OP_NOP;
        endcase
        push_uop.dest_mem     = dest_is_memory;
        push_uop.src_mem      = source_kind[1];
        push_uop.src_imm      = (source_kind == SRC_IMM);
        push_uop.dest_code    = dest_reg;
        push_uop.dest_ok      = reg_code_ok(dest_reg);
        push_uop.dest_idx     = reg_code_idx(dest_reg);
        push_uop.src_ok       = reg_code_ok(source_reg);
        push_uop.src_idx      = reg_code_idx(source_reg);
        push_uop.base_ok      = reg_code_ok(base_reg);
        push_uop.base_idx     = reg_code_idx(base_reg);
        push_uop.index_ok     = reg_code_ok(index_reg);
        push_uop.index_idx    = reg_code_idx(index_reg);
        push_uop.immediate    = immediate;
        push_uop.displacement = displacement;
        push_uop.length       = length;
    end

endmodule

>>> hw/rtl/xseu_queue.sv
module xseu_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  xseu_pkg::uop_t   push_uop,
    input  logic             pop,
    output xseu_pkg::uop_t   head_uop,
    output xseu_pkg::qstat_t q_stat
);
    import xseu_pkg::*;

    uop_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head_uop     = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates; pointers wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage carries payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_uop;
        end
    end

endmodule

>>> hw/rtl/xseu_back.sv
module xseu_back #(
    parameter int unsigned MEM_BYTES = xseu_pkg::MEM_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  xseu_pkg::uop_t   head_uop,
    input  xseu_pkg::qstat_t q_stat,
    output logic             q_pop,
    output logic             clearing,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [15:0]      next_ip,
    output logic             branch_taken,
    output logic             zero_out,
    output logic             sign_out,
    output logic [3:0]       reg_written,
    output logic [15:0]      reg_value,
    output logic             mem_written,
    output logic [15:0]      mem_address,
    output logic [15:0]      mem_value
);
    import xseu_pkg::*;

    // The byte memory is split into an even and an odd bank of words' halves.
    localparam int unsigned ADDR_W = $clog2(MEM_BYTES);
    localparam int unsigned ROW_W  = ADDR_W - 1;
    localparam int unsigned ROWS   = MEM_BYTES / 2;

    bstate_t state_reg;
    bstate_t state_next;
    logic [ROW_W-1:0] clr_cnt_reg;
    logic             clr_we;

    // Register file, held twice so that each copy needs only two read ports.
    logic [15:0] rf_a [NUM_REGS];
    logic [15:0] rf_b [NUM_REGS];
    logic                 rf_we;
    logic [REG_IDX_W-1:0] rf_wr_idx;
    logic [15:0]          rf_wr_data;

    logic [7:0] even_mem [ROWS];
    logic [7:0] odd_mem  [ROWS];

    logic        zf_reg;
    logic        sf_reg;
    logic [15:0] ip_reg;

    // Stage occupancy: address stage and execute stage.
    logic m_valid_reg;
    logic e_valid_reg;
    logic m_to_e;
    logic fire;

    uop_t        uop_reg;
    logic [15:0] base_val_reg;
    logic [15:0] index_val_reg;
    logic [15:0] dest_val_reg;
    logic [15:0] src_val_reg;
    logic [15:0] ea_reg;
    logic [15:0] ip_len_reg;
    logic [ROW_W-1:0] even_row_reg;
    logic [ROW_W-1:0] odd_row_reg;
    logic        odd_addr_reg;
    logic [7:0]  rd_even_reg;
    logic [7:0]  rd_odd_reg;

    logic [15:0]      ea_c;
    logic [ROW_W-1:0] p_row_c;
    logic [ROW_W-1:0] even_row_c;

    logic [15:0] mem_word;
    logic [15:0] op_a;
    logic [15:0] op_b;
    logic [15:0] result;
    logic        store;
    logic        set_flags;
    logic        taken;
    logic        zf_new;
    logic        sf_new;
    logic [15:0] ip_new;
    logic        reg_we;
    logic        mem_we;
    logic [7:0]  wr_even;
    logic [7:0]  wr_odd;

    logic        out_valid_reg;
    logic [15:0] next_ip_reg;
    logic        branch_taken_reg;
    logic        zero_out_reg;
    logic        sign_out_reg;
    logic [3:0]  reg_written_reg;
    logic [15:0] reg_value_reg;
    logic        mem_written_reg;
    logic [15:0] mem_address_reg;
    logic [15:0] mem_value_reg;

    assign clearing = (state_reg == BS_CLEAR);

    // Sequencing: clearing pass, then one word through address and execute stages.
    always_comb
    begin
        state_next = state_reg;
        clr_we     = 1'b0;
        fire       = 1'b0;
        m_to_e     = 1'b0;
        q_pop      = 1'b0;
        case (state_reg)
            BS_CLEAR:
            begin
                clr_we = 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = BS_RUN;
                end
            end
            BS_RUN:
            begin
                fire   = e_valid_reg && (!out_valid_reg || !out_stall);
                m_to_e = m_valid_reg && !e_valid_reg;
                q_pop  = !q_stat.empty && !m_valid_reg && (!e_valid_reg || fire);
            end
            default:
            begin
                state_next = BS_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BS_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_we)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            m_valid_reg <= q_pop || (m_valid_reg && !m_to_e);
            e_valid_reg <= m_to_e || (e_valid_reg && !fire);
        end
    end

    // Register file write: zeroes during the clearing pass, results afterwards.
    assign rf_we      = clr_we || reg_we;
    assign rf_wr_idx  = clr_we ? clr_cnt_reg[REG_IDX_W-1:0] : uop_reg.dest_idx;
    assign rf_wr_data = clr_we ? 16'h0000 : result;

    // Copy A serves the address registers, with the result of the word retiring
    // in the same cycle passed straight through.
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_a[rf_wr_idx] <= rf_wr_data;
        end
        if (q_pop)
        begin
            if (!head_uop.base_ok)
                base_val_reg <= '0;
            else if (rf_we && (rf_wr_idx == head_uop.base_idx))
                base_val_reg <= rf_wr_data;
            else
                base_val_reg <= rf_a[head_uop.base_idx];
            if (!head_uop.index_ok)
                index_val_reg <= '0;
            else if (rf_we && (rf_wr_idx == head_uop.index_idx))
                index_val_reg <= rf_wr_data;
            else
                index_val_reg <= rf_a[head_uop.index_idx];
        end
    end

    // Copy B serves the destination and source registers.
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_b[rf_wr_idx] <= rf_wr_data;
        end
        if (q_pop)
        begin
            if (!head_uop.dest_ok)
                dest_val_reg <= '0;
            else if (rf_we && (rf_wr_idx == head_uop.dest_idx))
                dest_val_reg <= rf_wr_data;
            else
                dest_val_reg <= rf_b[head_uop.dest_idx];
            if (!head_uop.src_ok)
                src_val_reg <= '0;
            else if (rf_we && (rf_wr_idx == head_uop.src_idx))
                src_val_reg <= rf_wr_data;
            else
                src_val_reg <= rf_b[head_uop.src_idx];
        end
    end

    // Address stage: effective address and the rows of both bytes of the word.
    assign ea_c       = base_val_reg + index_val_reg + uop_reg.displacement;
    assign p_row_c    = ea_c[ADDR_W-1:1];
    assign even_row_c = ea_c[0] ? p_row_c + 1'b1 : p_row_c;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            uop_reg <= head_uop;
        end
        if (m_to_e)
        begin
            ea_reg       <= ea_c;
            even_row_reg <= even_row_c;
            odd_row_reg  <= p_row_c;
            odd_addr_reg <= ea_c[0];
            ip_len_reg   <= ip_reg + {13'b0, uop_reg.length};
        end
    end

    // Even and odd byte banks; the clearing pass zeroes one row of each per cycle.
    always_ff @(posedge clk)
    begin
        if (clr_we)
            even_mem[clr_cnt_reg] <= '0;
        else if (mem_we)
            even_mem[even_row_reg] <= wr_even;
        if (m_to_e)
            rd_even_reg <= even_mem[even_row_c];
    end

    always_ff @(posedge clk)
    begin
        if (clr_we)
            odd_mem[clr_cnt_reg] <= '0;
        else if (mem_we)
            odd_mem[odd_row_reg] <= wr_odd;
        if (m_to_e)
            rd_odd_reg <= odd_mem[p_row_c];
    end

    // Execute stage: operands, arithmetic, flags and the new instruction pointer.
    assign mem_word = odd_addr_reg ? {rd_even_reg, rd_odd_reg} : {rd_odd_reg, rd_even_reg};
    assign op_a     = uop_reg.dest_mem ? mem_word : dest_val_reg;
    assign op_b     = uop_reg.src_mem ? mem_word :
                      (uop_reg.src_imm ? uop_reg.immediate : src_val_reg);

    always_comb
    begin
        result    = 16'h0000;
        store     = 1'b0;
        set_flags = 1'b0;
        taken     = 1'b0;
        case (uop_reg.op)
            OP_MOV:
            begin
                result = op_b;
                store  = 1'b1;
            end
            OP_ADD:
            begin
                result    = op_a + op_b;
                store     = 1'b1;
                set_flags = 1'b1;
            end
            OP_SUB:
            begin
                result    = op_a - op_b;
                store     = 1'b1;
                set_flags = 1'b1;
            end
            OP_CMP:
            begin
                result    = op_a - op_b;
                set_flags = 1'b1;
            end
            OP_JNE:
            begin
                taken = !zf_reg;
            end
            default:
            begin
                result = 16'h0000;
            end
        endcase
    end

    assign zf_new  = set_flags ? (result == 16'h0000) : zf_reg;
    assign sf_new  = set_flags ? ((result & SIGN_BIT) != 16'h0000) : sf_reg;
    assign ip_new  = taken ? ip_len_reg + uop_reg.immediate : ip_len_reg;
    assign reg_we  = fire && store && !uop_reg.dest_mem && uop_reg.dest_ok;
    assign mem_we  = fire && store && uop_reg.dest_mem;
    assign wr_even = odd_addr_reg ? result[15:8] : result[7:0];
    assign wr_odd  = odd_addr_reg ? result[7:0] : result[15:8];

    // Architectural flags and instruction pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zf_reg <= 1'b0;
            sf_reg <= 1'b0;
            ip_reg <= '0;
        end
        else if (fire)
        begin
            zf_reg <= zf_new;
            sf_reg <= sf_new;
            ip_reg <= ip_new;
        end
    end

    // Output register: holds a finished word while the next one is worked on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            next_ip_reg      <= ip_new;
            branch_taken_reg <= taken;
            zero_out_reg     <= zf_new;
            sign_out_reg     <= sf_new;
            reg_written_reg  <= reg_we ? uop_reg.dest_code : 4'd0;
            reg_value_reg    <= reg_we ? result : 16'h0000;
            mem_written_reg  <= mem_we;
            mem_address_reg  <= mem_we ? ea_reg : 16'h0000;
            mem_value_reg    <= mem_we ? result : 16'h0000;
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_ip      = next_ip_reg;
    assign branch_taken = branch_taken_reg;
    assign zero_out     = zero_out_reg;
    assign sign_out     = sign_out_reg;
    assign reg_written  = reg_written_reg;
    assign reg_value    = reg_value_reg;
    assign mem_written  = mem_written_reg;
    assign mem_address  = mem_address_reg;
    assign mem_value    = mem_value_reg;

    // The address and execute stages never hold a word at the same time.
    a_single_stage: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !e_valid_reg)
        else $error("address and execute stages both occupied");

    // Nothing enters the back end while memory is being cleared.
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (!q_pop && !m_valid_reg && !e_valid_reg))
        else $error("word in flight during clearing pass");

    // The instruction pointer moves only when a word retires.
    a_ip_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(ip_reg))
        else $error("instruction pointer changed without a retiring word");

    // A result never reports both a register and a memory write.
    a_one_dest: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(mem_written_reg && (reg_written_reg != 4'd0)))
        else $error("register and memory written by one word");

    // A taken branch changes neither registers nor memory.
    a_branch_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && branch_taken_reg) |-> ((reg_written_reg == 4'd0) && !mem_written_reg))
        else $error("taken branch reported a write");

endmodule

>>> hw/rtl/x86_16_subset_execute_unit_top.sv
// Channel  | Direction | Handshake           | Word contents
// ---------+-----------+---------------------+-------------------------------------------
// input    | in        | in_valid / in_stall | decoded instruction: kind .. length
// output   | out       | out_valid/out_stall | next_ip, flags, register and memory write
//
// In the back end an instruction passes an address stage, which forms the effective
// address from registered register reads and reads both memory banks, then an execute
// stage, which executes and writes back; the next leaves the queue only as it retires
// or when both stages are empty. After reset a clearing pass zeroes the data memory and
// registers, one row of each byte bank per cycle; in_stall is high meanwhile.
// A two-word queue lets the input side fill while the output side is stalled,
// and the output register holds a finished word until it is taken.
module x86_16_subset_execute_unit_top #(
    parameter int unsigned MEM_BYTES = xseu_pkg::MEM_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic        dest_is_memory,
    input  logic [1:0]  source_kind,
    input  logic [3:0]  dest_reg,
    input  logic [3:0]  source_reg,
    input  logic [3:0]  base_reg,
    input  logic [3:0]  index_reg,
    input  logic [15:0] immediate,
    input  logic [15:0] displacement,
    input  logic [2:0]  length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] next_ip,
    output logic        branch_taken,
    output logic        zero_out,
    output logic        sign_out,
    output logic [3:0]  reg_written,
    output logic [15:0] reg_value,
    output logic        mem_written,
    output logic [15:0] mem_address,
    output logic [15:0] mem_value
);
    import xseu_pkg::*;

    logic   clearing;
    logic   push;
    logic   q_pop;
    uop_t   push_uop;
    uop_t   head_uop;
    qstat_t q_stat;

    // Front: accepts and classifies instruction words.
    xseu_front u_front (
        .kind           (kind),
        .dest_is_memory (dest_is_memory),
        .source_kind    (source_kind),
        .dest_reg       (dest_reg),
        .source_reg     (source_reg),
        .base_reg       (base_reg),
        .index_reg      (index_reg),
        .immediate      (immediate),
        .displacement   (displacement),
        .length         (length),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .clearing       (clearing),
        .q_stat         (q_stat),
        .push           (push),
        .push_uop       (push_uop)
    );

    // Queue between front and back.
    xseu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_uop (push_uop),
        .pop      (q_pop),
        .head_uop (head_uop),
        .q_stat   (q_stat)
    );

    // Back: address generation, memory access, execution and write back.
    xseu_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_uop     (head_uop),
        .q_stat       (q_stat),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .next_ip      (next_ip),
        .branch_taken (branch_taken),
        .zero_out     (zero_out),
        .sign_out     (sign_out),
        .reg_written  (reg_written),
        .reg_value    (reg_value),
        .mem_written  (mem_written),
        .mem_address  (mem_address),
        .mem_value    (mem_value)
    );

endmodule
